@@ design/qmn_pkg.sv @@
// ----------------------------------------------------------------------------
// qmn_pkg
// Shared constants and types for the normalized quaternion product pipeline.
// ----------------------------------------------------------------------------
package qmn_pkg;

  localparam int FRAC_BITS_DEF = 29;
  localparam int WORD_BITS_DEF = 32;
  localparam int LANES         = 4;
  localparam int TERMS         = 16;

  // Hamilton product term table, entry 4*k+t is term t of component k.
  // Left index, right index and subtract flag.
  localparam logic [1:0] HT_L [TERMS] = '{
    2'd0, 2'd1, 2'd2, 2'd3,
    2'd0, 2'd1, 2'd2, 2'd3,
    2'd0, 2'd2, 2'd3, 2'd1,
    2'd0, 2'd3, 2'd1, 2'd2
  };
  localparam logic [1:0] HT_R [TERMS] = '{
    2'd0, 2'd1, 2'd2, 2'd3,
    2'd1, 2'd0, 2'd3, 2'd2,
    2'd2, 2'd0, 2'd1, 2'd3,
    2'd3, 2'd0, 2'd2, 2'd1
  };
  localparam logic HT_SUB [TERMS] = '{
    1'b0, 1'b1, 1'b1, 1'b1,
    1'b0, 1'b0, 1'b0, 1'b1,
    1'b0, 1'b0, 1'b0, 1'b1,
    1'b0, 1'b0, 1'b0, 1'b1
  };

  // Per-item flags that ride along with the root stages
  typedef struct packed {
    logic [LANES-1:0] neg;   // component sign
    logic [LANES-1:0] top;   // only nonzero component: result is exactly one
    logic             zero;  // whole product is zero
  } qmn_ctrl_t;

endpackage

@@ design/qmn_root_step.sv @@
// ----------------------------------------------------------------------------
// qmn_root_step
// One registered digit of the ratio square root, four lanes sharing the
// squared length. Decides one bit of m = floor(sqrt(4 c^2 2^2F / S)).
// ----------------------------------------------------------------------------
module qmn_root_step import qmn_pkg::*; #(
  parameter int SW = 132,  // squared length width
  parameter int MB = 30    // root digit count
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [SW-1:0] s_i,
  input  logic [SW+MB+2:0] e_i [LANES],
  input  logic [SW+MB-1:0] p_i [LANES],
  input  logic [MB-1:0] m_i [LANES],
  output logic [SW-1:0] s_o,
  output logic [SW+MB+2:0] e_o [LANES],
  output logic [SW+MB-1:0] p_o [LANES],
  output logic [MB-1:0] m_o [LANES]
);

  localparam int PW = SW + MB;
  localparam int EW = SW + MB + 3;

  logic [EW-1:0] trial [LANES];
  logic [EW-1:0] e_nxt [LANES];
  logic [PW-1:0] p_nxt [LANES];
  logic          take  [LANES];

  // trial subtract of (4M+1)*S, kept as 4P+S
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      trial[l] = (EW'(p_i[l]) << 2) + EW'(s_i);
      take[l]  = (trial[l] <= e_i[l]);
      e_nxt[l] = take[l] ? (e_i[l] - trial[l]) : e_i[l];
      p_nxt[l] = (p_i[l] << 1) + (take[l] ? PW'(s_i) : PW'(0));
    end
  end

  // stage register
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_o <= s_i;
      for (int l = 0; l < LANES; l++) begin
        e_o[l] <= e_nxt[l] << 2;
        p_o[l] <= p_nxt[l];
        m_o[l] <= {m_i[l][MB-2:0], take[l]};
      end
    end
  end

endmodule

@@ design/quaternion_multiply_normalize.sv @@
// ----------------------------------------------------------------------------
// quaternion_multiply_normalize
// Hamilton product of two fixed point quaternions, each component divided
// by the product length and rounded to nearest, ties away from zero.
//
//   channel | signals                               | direction
//   in      | in_valid_i, in_ready_o, left_*, right_* | request in
//   out     | out_valid_o, out_ready_i, prod_*, zero_length_o | request out
//
// One request accepted per cycle while the output is not stalled; the
// FRAC_BITS + 1 root digit stages follow five arithmetic stages.
// The whole pipeline advances together whenever the output register is
// empty or being taken; a stall freezes every stage in place.
// Reset clears only the valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
module quaternion_multiply_normalize import qmn_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic signed [WORD_BITS-1:0] left_w_i,
  input  logic signed [WORD_BITS-1:0] left_x_i,
  input  logic signed [WORD_BITS-1:0] left_y_i,
  input  logic signed [WORD_BITS-1:0] left_z_i,
  input  logic signed [WORD_BITS-1:0] right_w_i,
  input  logic signed [WORD_BITS-1:0] right_x_i,
  input  logic signed [WORD_BITS-1:0] right_y_i,
  input  logic signed [WORD_BITS-1:0] right_z_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [FRAC_BITS+1:0] prod_w_o,
  output logic signed [FRAC_BITS+1:0] prod_x_o,
  output logic signed [FRAC_BITS+1:0] prod_y_o,
  output logic signed [FRAC_BITS+1:0] prod_z_o,
  output logic                        zero_length_o
);

  localparam int WB  = WORD_BITS;
  localparam int PRW = 2 * WB;         // one l*r product
  localparam int CW  = 2 * WB + 2;     // signed component sum
  localparam int MW  = 2 * WB + 1;     // component magnitude
  localparam int H   = WB + 1;         // low half of magnitude
  localparam int HW  = MW - H;         // high half of magnitude
  localparam int SQW = 2 * MW;         // component square
  localparam int SW  = 4 * WB + 4;     // squared length
  localparam int MB  = FRAC_BITS + 1;  // root digits
  localparam int PW  = SW + MB;
  localparam int EW  = SW + MB + 3;
  localparam int OW  = FRAC_BITS + 2;
  localparam int NST = 5 + MB + 1;     // total register stages

  logic           en;
  logic [NST-1:0] v_q;

  // whole-pipeline advance
  assign en          = out_ready_i | ~v_q[NST-1];
  assign in_ready_o  = en;
  assign out_valid_o = v_q[NST-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NST-2:0], in_valid_i};
    end
  end

  logic signed [WB-1:0] lv [LANES];
  logic signed [WB-1:0] rv [LANES];

  assign lv[0] = left_w_i;
  assign lv[1] = left_x_i;
  assign lv[2] = left_y_i;
  assign lv[3] = left_z_i;
  assign rv[0] = right_w_i;
  assign rv[1] = right_x_i;
  assign rv[2] = right_y_i;
  assign rv[3] = right_z_i;

  // stage 1: sixteen partial products
  logic signed [PRW-1:0] pr_q [TERMS];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < TERMS; i++) begin
        pr_q[i] <= lv[HT_L[i]] * rv[HT_R[i]];
      end
    end
  end

  // stage 2: component sums, sign and magnitude
  logic signed [CW-1:0] csum [LANES];
  logic [MW-1:0]        mag_q [LANES];
  logic [LANES-1:0]     neg2_q;

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      csum[k] = '0;
      for (int t = 0; t < LANES; t++) begin
        if (HT_SUB[4*k+t]) begin
          csum[k] = csum[k] - CW'(pr_q[4*k+t]);
        end else begin
          csum[k] = csum[k] + CW'(pr_q[4*k+t]);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < LANES; k++) begin
        neg2_q[k] <= csum[k][CW-1];
        mag_q[k]  <= csum[k][CW-1] ? MW'(-csum[k]) : MW'(csum[k]);
      end
    end
  end

  // stage 3: split squares into half-width products
  logic [2*HW-1:0] aa_q [LANES];
  logic [HW+H-1:0] ab_q [LANES];
  logic [2*H-1:0]  bb_q [LANES];
  logic [LANES-1:0] neg3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      neg3_q <= neg2_q;
      for (int k = 0; k < LANES; k++) begin
        aa_q[k] <= mag_q[k][MW-1:H] * mag_q[k][MW-1:H];
        ab_q[k] <= mag_q[k][MW-1:H] * mag_q[k][H-1:0];
        bb_q[k] <= mag_q[k][H-1:0] * mag_q[k][H-1:0];
      end
    end
  end

  // stage 4: assemble component squares
  logic [SQW-1:0]   sq_q [LANES];
  logic [LANES-1:0] neg4_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      neg4_q <= neg3_q;
      for (int k = 0; k < LANES; k++) begin
        sq_q[k] <= (SQW'(aa_q[k]) << (2 * H)) + (SQW'(ab_q[k]) << (H + 1)) + SQW'(bb_q[k]);
      end
    end
  end

  // stage 5: squared length, flags, initial remainders
  logic [SW-1:0]    s_a  [MB+1];
  logic [EW-1:0]    e_a  [MB+1][LANES];
  logic [PW-1:0]    p_a  [MB+1][LANES];
  logic [MB-1:0]    m_a  [MB+1][LANES];
  qmn_ctrl_t        ctrl_q [MB+1];
  logic [LANES-1:0] sq_nz;

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      sq_nz[k] = |sq_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s_a[0] <= SW'(sq_q[0]) + SW'(sq_q[1]) + SW'(sq_q[2]) + SW'(sq_q[3]);
      ctrl_q[0].neg  <= neg4_q;
      ctrl_q[0].zero <= ~|sq_nz;
      for (int k = 0; k < LANES; k++) begin
        ctrl_q[0].top[k] <= ((sq_nz & ~(LANES'(1) << k)) == '0);
        e_a[0][k] <= EW'(sq_q[k]) << 2;
        p_a[0][k] <= '0;
        m_a[0][k] <= '0;
      end
    end
  end

  // root digit stages, most significant digit first
  for (genvar j = 0; j < MB; j++) begin : g_root
    qmn_root_step #(
      .SW(SW),
      .MB(MB)
    ) u_step (
      .clk_i(clk_i),
      .en_i (en),
      .s_i  (s_a[j]),
      .e_i  (e_a[j]),
      .p_i  (p_a[j]),
      .m_i  (m_a[j]),
      .s_o  (s_a[j+1]),
      .e_o  (e_a[j+1]),
      .p_o  (p_a[j+1]),
      .m_o  (m_a[j+1])
    );

    always_ff @(posedge clk_i) begin
      if (en) begin
        ctrl_q[j+1] <= ctrl_q[j];
      end
    end
  end

  // final stage: round half up on the root, sign, zero override
  logic [MB-1:0]  nmag [LANES];
  logic [OW-1:0]  oval [LANES];
  logic [OW-1:0]  out_q [LANES];
  logic           zero_q;
  qmn_ctrl_t      cf;

  assign cf = ctrl_q[MB];

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      if (cf.top[k]) begin
        nmag[k] = MB'(1) << FRAC_BITS;
      end else begin
        nmag[k] = MB'(((MB+1)'(m_a[MB][k]) + (MB+1)'(1)) >> 1);
      end
      if (cf.zero) begin
        oval[k] = '0;
      end else if (cf.neg[k]) begin
        oval[k] = -OW'(nmag[k]);
      end else begin
        oval[k] = OW'(nmag[k]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q  <= oval;
      zero_q <= cf.zero;
    end
  end

  assign prod_w_o      = out_q[0];
  assign prod_x_o      = out_q[1];
  assign prod_y_o      = out_q[2];
  assign prod_z_o      = out_q[3];
  assign zero_length_o = zero_q;

endmodule
